// ----- src/set_assoc_cache_lru_lookup_top_assert.svh -----
// Assertion macros for the LRU cache lookup block.
// Used by the top level and the tag store; expects clk and rst_n in scope.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SALRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SALRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/salru_pkg.sv -----
// Shared constants, types and helpers for the LRU cache lookup block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package salru_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_WAYS   = 4;
  localparam int DEF_MAX_SETS   = 128;
  localparam int DEF_ADDR_WIDTH = 32;
  localparam int DEF_AGE_WIDTH  = 16;

  // fixed field widths
  localparam int SET_NUM_W  = 7;
  localparam int WAY_IDX_W  = 4;   // enough for up to 16 ways
  localparam int WAY_OUT_W  = 2;
  localparam int CNT_W      = 32;
  localparam int OFF_W      = 4;
  localparam int IDX_W      = 3;
  localparam int WAYS_W     = 3;
  localparam int SHIFT_W    = 5;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // register reset values
  localparam logic [OFF_W-1:0]  RST_OFFSET_BITS = 4'd5;
  localparam logic [IDX_W-1:0]  RST_INDEX_BITS  = 3'd6;
  localparam logic [WAYS_W-1:0] RST_WAYS_IN_USE = 3'd2;

  // access kinds; anything else is looked up and counted as a hit or miss, but not as a read or write
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [WAY_IDX_W-1:0] pick;
  } lookup_t;

  // result beat, last field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     write_total;
    logic [CNT_W-1:0]     read_total;
    logic                 evicted;
    logic [SET_NUM_W-1:0] set_number;
    logic [WAY_OUT_W-1:0] way;
    logic                 hit;
  } result_t;

  localparam int RESULT_W    = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

  // Reduce a narrow set index modulo the set count by restoring subtraction.
  function automatic logic [SET_NUM_W-1:0] set_wrap(input logic [SET_NUM_W-1:0] raw,
                                                    input int sets);
    logic [SET_NUM_W-1:0] r;
    r = raw;
    for (int k = SET_NUM_W - 1; k >= 0; k--) begin
      if (int'(r) >= (sets << k)) begin
        r = r - SET_NUM_W'(sets << k);
      end
    end
    return r;
  endfunction

endpackage

// ----- src/salru_addr_split.sv -----
// Splits a byte address into set index and tag under the current geometry.
// Depends on salru_pkg.
`timescale 1ns / 1ps

module salru_addr_split #(
  parameter int ADDR_WIDTH = salru_pkg::DEF_ADDR_WIDTH,
  parameter int MAX_SETS   = salru_pkg::DEF_MAX_SETS
) (
  input  logic [ADDR_WIDTH-1:0]           addr,
  input  logic [salru_pkg::OFF_W-1:0]     offset_bits,
  input  logic [salru_pkg::IDX_W-1:0]     index_bits,
  output logic [salru_pkg::SET_NUM_W-1:0] set_number,
  output logic [ADDR_WIDTH-1:0]           tag
);
  import salru_pkg::*;

  logic [ADDR_WIDTH-1:0] shifted;
  logic [SET_NUM_W:0]    idx_mask;
  logic [SET_NUM_W-1:0]  set_raw;
  logic [SHIFT_W-1:0]    tag_shift;

  assign shifted   = addr >> offset_bits;
  assign idx_mask  = (SET_NUM_W+1)'(1) << index_bits;
  assign set_raw   = shifted[SET_NUM_W-1:0] & SET_NUM_W'(idx_mask - (SET_NUM_W+1)'(1));
  assign tag_shift = SHIFT_W'(offset_bits) + SHIFT_W'(index_bits);
  assign tag       = addr >> tag_shift;

  // indexes past the store wrap round
  assign set_number = set_wrap(set_raw, MAX_SETS);

endmodule

// ----- src/salru_tag_store.sv -----
// Tag store: one row per set holding every way's valid bit, tag and age.
// Registered read, same-set forwarding from the write port, per-row init flags.
// Depends on salru_pkg and the assertion header.
`timescale 1ns / 1ps

`include "set_assoc_cache_lru_lookup_top_assert.svh"

module salru_tag_store #(
  parameter int MAX_SETS = salru_pkg::DEF_MAX_SETS,
  parameter int ROW_W    = 196
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [salru_pkg::SET_NUM_W-1:0] rd_set,
  input  logic                            wr_en,
  input  logic [salru_pkg::SET_NUM_W-1:0] wr_set,
  input  logic [ROW_W-1:0]                wr_row,
  output logic [ROW_W-1:0]                rd_row
);
  import salru_pkg::*;

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  logic [ROW_W-1:0]    mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_init_r;
  logic [ROW_W-1:0]    rd_raw_r;
  logic [ROW_W-1:0]    byp_row_r;
  logic                byp_r;
  logic                init_r;
  logic [SET_W-1:0]    rd_idx;
  logic [SET_W-1:0]    wr_idx;
  logic                same_set;

  assign rd_idx   = SET_W'(rd_set);
  assign wr_idx   = SET_W'(wr_set);
  assign same_set = wr_en && (wr_set == rd_set);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_idx];
    end
  end

  // a row never written reads as all clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (wr_en) begin
      row_init_r[wr_idx] <= 1'b1;
    end
  end

  // write landing on the row being read wins over the stale memory word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r  <= 1'b0;
      init_r <= 1'b0;
    end else if (rd_en) begin
      byp_r  <= same_set;
      init_r <= row_init_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_row_r <= wr_row;
    end
  end

  assign rd_row = byp_r ? byp_row_r : (init_r ? rd_raw_r : '0);

  `SALRU_ASSERT_NEXT(a_row_marked, rst_n && wr_en, row_init_r[$past(wr_idx)], "row written but not marked")
  `SALRU_ASSERT_NEXT(a_forward, rst_n && rd_en && same_set, rd_row == $past(wr_row), "same-set forwarding lost")
  `SALRU_ASSERT_NEXT(a_read_hold, rst_n && !rd_en, $stable(rd_row), "read data moved without a read")

endmodule

// ----- src/salru_lru_update.sv -----
// Way search and LRU update for one set row: hit detect, victim choice, ageing.
// Purely combinational; depends on salru_pkg.
`timescale 1ns / 1ps

module salru_lru_update #(
  parameter int MAX_WAYS   = salru_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH = salru_pkg::DEF_ADDR_WIDTH,
  parameter int AGE_WIDTH  = salru_pkg::DEF_AGE_WIDTH
) (
  input  logic [MAX_WAYS-1:0]                 use_mask,
  input  logic [ADDR_WIDTH-1:0]               tag,
  input  logic [MAX_WAYS-1:0]                 valid_in,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_in,
  input  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  age_in,
  output logic [MAX_WAYS-1:0]                 valid_out,
  output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_out,
  output logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  age_out,
  output salru_pkg::lookup_t                  res
);
  import salru_pkg::*;

  logic                 hit;
  logic [WAY_IDX_W-1:0] hit_way;
  logic                 free_found;
  logic [WAY_IDX_W-1:0] free_way;
  logic [WAY_IDX_W-1:0] old_way;
  logic [AGE_WIDTH-1:0] best_age;
  logic [WAY_IDX_W-1:0] pick;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    old_way    = '0;
    best_age   = age_in[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && use_mask[w] && valid_in[w] && (tag_in[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_IDX_W'(w);
      end
      if (!free_found && use_mask[w] && !valid_in[w]) begin
        free_found = 1'b1;
        free_way   = WAY_IDX_W'(w);
      end
    end
    // oldest way, lowest index on a tie; way 0 is always in use
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (use_mask[w] && (age_in[w] > best_age)) begin
        best_age = age_in[w];
        old_way  = WAY_IDX_W'(w);
      end
    end
    pick = hit ? hit_way : (free_found ? free_way : old_way);
  end

  always_comb begin
    valid_out = valid_in;
    tag_out   = tag_in;
    age_out   = age_in;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_IDX_W'(w) == pick) begin
        valid_out[w] = 1'b1;
        if (!hit) begin
          tag_out[w] = tag;
        end
        age_out[w] = '0;
      end else if (use_mask[w] && valid_in[w] && (age_in[w] != '1)) begin
        age_out[w] = age_in[w] + AGE_WIDTH'(1);
      end
    end
  end

  assign res.hit     = hit;
  assign res.evicted = !hit && !free_found;
  assign res.pick    = pick;

endmodule

// ----- src/set_assoc_cache_lru_lookup_top.sv -----
// Set-associative tag lookup with LRU replacement. Takes one address beat per
// clock while the output is not stalled and returns one result beat per
// address, in order: hit flag, way hit or filled, set index, eviction flag and
// the running read/write/hit/miss counts. The edge that takes a beat also reads
// its set row from the tag store; when stage 1 fires, the updated row is written
// back and the result register is loaded. Throughput is one beat per clock when
// not stalled, set by the single read-modify-write of the set row; a back-to-back
// access to the same set is served by forwarding the row being written. The tag
// store is MAX_SETS rows by MAX_WAYS ways of valid, tag and age; per-row flags
// cleared at reset make it read as empty, so no clearing pass is needed and
// beats are taken from the first cycle after reset. Registers are to be written
// through the cfg port only while no access is in flight; no check enforces it.
// Depends on salru_pkg, salru_addr_split, salru_tag_store, salru_lru_update.
`timescale 1ns / 1ps

`include "set_assoc_cache_lru_lookup_top_assert.svh"

module set_assoc_cache_lru_lookup_top #(
  parameter int MAX_WAYS   = salru_pkg::DEF_MAX_WAYS,
  parameter int MAX_SETS   = salru_pkg::DEF_MAX_SETS,
  parameter int ADDR_WIDTH = salru_pkg::DEF_ADDR_WIDTH,
  parameter int AGE_WIDTH  = salru_pkg::DEF_AGE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // address beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((ADDR_WIDTH+7)/8)*8-1:0]     in_tdata,   // address, zero pad
  input  logic [salru_pkg::ACTION_W-1:0]      in_tuser,   // action
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit, way, set_number, evicted, read_total, write_total, hit_total,
  // miss_total, zero pad
  output logic [salru_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import salru_pkg::*;

  localparam int ROW_W = MAX_WAYS * (1 + ADDR_WIDTH + AGE_WIDTH);

  // configuration
  logic [OFF_W-1:0]  offset_bits_r;
  logic [IDX_W-1:0]  index_bits_r;
  logic [WAYS_W-1:0] ways_in_use_r;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= RST_OFFSET_BITS;
      index_bits_r  <= RST_INDEX_BITS;
      ways_in_use_r <= RST_WAYS_IN_USE;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits_r <= cfg_data[OFF_W-1:0];
        REG_INDEX_BITS:  index_bits_r  <= cfg_data[IDX_W-1:0];
        REG_WAYS_IN_USE: ways_in_use_r <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // ways searched; zero means one, anything past the store is capped by width
  logic [MAX_WAYS-1:0] use_mask;
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      use_mask[w] = (w == 0) || (w < int'(ways_in_use_r));
    end
  end

  // handshake and pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic s1_fire;
  logic in_acc;

  assign advance   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // address decode on the incoming beat
  logic [SET_NUM_W-1:0]  in_set;
  logic [ADDR_WIDTH-1:0] in_tag;

  salru_addr_split #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .MAX_SETS   (MAX_SETS)
  ) u_split (
    .addr        (in_tdata[ADDR_WIDTH-1:0]),
    .offset_bits (offset_bits_r),
    .index_bits  (index_bits_r),
    .set_number  (in_set),
    .tag         (in_tag)
  );

  // stage 1 holds the beat while its row is read
  logic [SET_NUM_W-1:0]  s1_set_r;
  logic [ADDR_WIDTH-1:0] s1_tag_r;
  logic [ACTION_W-1:0]   s1_action_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_set_r    <= in_set;
      s1_tag_r    <= in_tag;
      s1_action_r <= in_tuser;
    end
  end

  logic [ROW_W-1:0]                 rd_row;
  logic [ROW_W-1:0]                 wr_row;
  logic [MAX_WAYS-1:0]              valid_in, valid_out;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_in, tag_out;
  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  age_in, age_out;
  lookup_t                          res;

  salru_tag_store #(
    .MAX_SETS (MAX_SETS),
    .ROW_W    (ROW_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc),
    .rd_set (in_set),
    .wr_en  (s1_fire),
    .wr_set (s1_set_r),
    .wr_row (wr_row),
    .rd_row (rd_row)
  );

  assign {valid_in, tag_in, age_in} = rd_row;
  assign wr_row = {valid_out, tag_out, age_out};

  salru_lru_update #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .AGE_WIDTH  (AGE_WIDTH)
  ) u_lru (
    .use_mask  (use_mask),
    .tag       (s1_tag_r),
    .valid_in  (valid_in),
    .tag_in    (tag_in),
    .age_in    (age_in),
    .valid_out (valid_out),
    .tag_out   (tag_out),
    .age_out   (age_out),
    .res       (res)
  );

  // running counts, each beat's totals include itself
  logic [CNT_W-1:0] reads_r, reads_nxt;
  logic [CNT_W-1:0] writes_r, writes_nxt;
  logic [CNT_W-1:0] hits_r, hits_nxt;
  logic [CNT_W-1:0] misses_r, misses_nxt;

  assign reads_nxt  = reads_r + CNT_W'(s1_action_r == ACT_READ);
  assign writes_nxt = writes_r + CNT_W'(s1_action_r == ACT_WRITE);
  assign hits_nxt   = hits_r + CNT_W'(res.hit);
  assign misses_nxt = misses_r + CNT_W'(!res.hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reads_r  <= '0;
      writes_r <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (s1_fire) begin
      reads_r  <= reads_nxt;
      writes_r <= writes_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  result_t out_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r.hit         <= res.hit;
      out_r.way         <= WAY_OUT_W'(res.pick);
      out_r.set_number  <= s1_set_r;
      out_r.evicted     <= res.evicted;
      out_r.read_total  <= reads_nxt;
      out_r.write_total <= writes_nxt;
      out_r.hit_total   <= hits_nxt;
      out_r.miss_total  <= misses_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_r};

  `SALRU_ASSERT_NEXT(a_result_loaded, rst_n && s1_fire, out_valid_r, "lookup fired but no result")
  `SALRU_ASSERT_NEXT(a_one_count, rst_n && s1_fire, (hits_r + misses_r) == ($past(hits_r) + $past(misses_r) + 32'd1), "hit plus miss count off")
  `SALRU_ASSERT_NOW(a_hit_no_evict, out_valid_r, !(out_r.hit && out_r.evicted), "hit reported an eviction")

endmodule
